// ===== design/slm_pkg.sv =====
// Shared types and codes for the generational slot map.
// Holds field widths, operation and status codes, controller states and the result word.
// No dependencies.
package slm_pkg;

  localparam int OP_W     = 2;
  localparam int ID_W     = 8;
  localparam int HGEN_W   = 16;
  localparam int STATUS_W = 2;
  localparam int DENSE_W  = 8;
  localparam int LIVE_W   = 9;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_FINISH,
    S_MOVE,
    S_RESP
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     result_id;
    logic [HGEN_W-1:0]   result_generation;
    logic [DENSE_W-1:0]  dense_index;
    logic                hit;
    logic                moved;
    logic [DENSE_W-1:0]  moved_from;
    logic [DENSE_W-1:0]  moved_to;
    logic [LIVE_W-1:0]   live_count;
  } rsp_word_t;

endpackage

// ===== design/slm_req_if.sv =====
// Request channel of the slot map: valid/ready plus the operation word.
// Depends on slm_pkg for field widths.
interface slm_req_if;
  import slm_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ID_W-1:0]   slot_id;
  logic [HGEN_W-1:0] handle_generation;

  modport source (output valid, output op, output slot_id, output handle_generation,
                  input ready);
  modport sink   (input valid, input op, input slot_id, input handle_generation,
                  output ready);
endinterface

// ===== design/slm_rsp_if.sv =====
// Response channel of the slot map: valid/ready plus the result word fields.
// Depends on slm_pkg for field widths.
interface slm_rsp_if;
  import slm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     result_id;
  logic [HGEN_W-1:0]   result_generation;
  logic [DENSE_W-1:0]  dense_index;
  logic                hit;
  logic                moved;
  logic [DENSE_W-1:0]  moved_from;
  logic [DENSE_W-1:0]  moved_to;
  logic [LIVE_W-1:0]   live_count;

  modport source (output valid, output status, output result_id, output result_generation,
                  output dense_index, output hit, output moved, output moved_from,
                  output moved_to, output live_count, input ready);
  modport sink   (input valid, input status, input result_id, input result_generation,
                  input dense_index, input hit, input moved, input moved_from,
                  input moved_to, input live_count, output ready);
endinterface

// ===== design/generational_slot_map_unit.sv =====
// Top level of the generational slot map: controller, output register and two table RAMs.
// Depends on slm_pkg, slm_req_if, slm_rsp_if and slm_ram.

// Generational slot map. Hands out ids from a dense array, frees them with a
// swap-with-last so live ids stay packed at dense positions 0..live_count-1,
// and validates (id, generation) handles. Each id carries a generation that
// advances on every free and wraps at GEN_BITS bits; a lookup hits when the
// handle's generation matches. Allocate on a full table returns status full,
// free of an id that is not live returns status not-live; neither changes state.
// The state lives in two RAMs: a dense table (dense position -> id) and an id
// table (id -> dense position and generation). One word is in flight at a time;
// it is accepted in the idle state and the next one is taken once the result
// has moved to the output register, so a stalled output costs at most one word
// of work. Accept-to-accept: lookup, no-op, allocate on a full table and a
// rejected free pass through DECIDE and RESP, a granted allocate and a free
// without a move add FINISH, and a free with a move adds FINISH and MOVE. The
// steps follow from the registered read data of the tables (allocate reads the
// dense table, then the id table at the id it found) and from the single write
// port of the dense table, which a moving free must write twice. After reset a
// clearing pass writes the identity mapping and zero generations into both
// tables, one entry a cycle, with req.ready low.
module generational_slot_map_unit #(
  parameter int SLOTS    = 256,
  parameter int GEN_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  slm_req_if.sink   req,
  slm_rsp_if.source rsp
);
  import slm_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef struct packed {
    logic [IDX_W-1:0]    dense;
    logic [GEN_BITS-1:0] gen;
  } id_entry_t;

  // controller state
  state_t           state, state_next;
  logic [IDX_W-1:0] clr_idx, clr_idx_next;
  logic [CNT_W-1:0] live, live_next;

  // captured request word
  op_t               op_r;
  logic [ID_W-1:0]   id_r;
  logic [HGEN_W-1:0] hgen_r;

  // per-word working registers
  logic [IDX_W-1:0]    pos, pos_next;
  logic [GEN_BITS-1:0] gen_new, gen_new_next;
  logic [IDX_W-1:0]    rid, rid_next;
  logic [IDX_W-1:0]    last_id, last_id_next;
  rsp_word_t           res, res_next, base;

  // output register
  logic      out_valid;
  logic      out_load;
  rsp_word_t out_word;

  // table ports
  logic             d2i_we;
  logic [IDX_W-1:0] d2i_waddr, d2i_wdata, d2i_raddr, d2i_rdata;
  logic             idm_we;
  logic [IDX_W-1:0] idm_waddr, idm_raddr;
  id_entry_t        idm_wdata, idm_rdata;

  logic             full;
  logic             id_ok;
  logic             not_live;
  logic             gen_match;
  logic [IDX_W-1:0] id_idx;
  logic [IDX_W-1:0] tail_pos;
  logic [CNT_W-1:0] live_inc, live_dec;

  slm_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_dense_ram (
    .clk   (clk),
    .we    (d2i_we),
    .waddr (d2i_waddr),
    .wdata (d2i_wdata),
    .raddr (d2i_raddr),
    .rdata (d2i_rdata)
  );

  slm_ram #(.WIDTH(IDX_W + GEN_BITS), .DEPTH(SLOTS)) u_id_ram (
    .clk   (clk),
    .we    (idm_we),
    .waddr (idm_waddr),
    .wdata (idm_wdata),
    .raddr (idm_raddr),
    .rdata (idm_rdata)
  );

  assign full      = (live == CNT_W'(SLOTS));
  assign id_ok     = ({{(32 - ID_W){1'b0}}, id_r} < 32'(SLOTS));
  assign id_idx    = IDX_W'(id_r);
  assign live_inc  = live + CNT_W'(1);
  assign live_dec  = live - CNT_W'(1);
  assign tail_pos  = IDX_W'(live_dec);
  // a free is legal only when the id sits inside the packed live region
  assign not_live  = (CNT_W'(idm_rdata.dense) >= live);
  // handle generation is masked to GEN_BITS before the compare
  assign gen_match = (idm_rdata.gen == GEN_BITS'(hgen_r));

  assign req.ready = (state == S_IDLE);

  // default result word: echo id, live count before any update
  always_comb begin
    base                   = '0;
    base.status            = ST_OK;
    base.result_id         = id_r;
    base.live_count        = LIVE_W'(live);
  end

  always_comb begin
    state_next   = state;
    clr_idx_next = clr_idx;
    live_next    = live;
    pos_next     = pos;
    gen_new_next = gen_new;
    rid_next     = rid;
    last_id_next = last_id;
    res_next     = res;
    out_load     = 1'b0;

    d2i_we    = 1'b0;
    d2i_waddr = '0;
    d2i_wdata = '0;
    d2i_raddr = IDX_W'(live);
    idm_we    = 1'b0;
    idm_waddr = '0;
    idm_wdata = '0;
    idm_raddr = id_idx;

    unique case (state)
      S_CLEAR: begin
        // write identity mapping and zero generation, one entry a cycle
        d2i_we          = 1'b1;
        d2i_waddr       = clr_idx;
        d2i_wdata       = clr_idx;
        idm_we          = 1'b1;
        idm_waddr       = clr_idx;
        idm_wdata.dense = clr_idx;
        idm_wdata.gen   = '0;
        clr_idx_next    = clr_idx + IDX_W'(1);
        if (clr_idx == IDX_W'(SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        // start the id table read straight off the request word; the dense table reads at live
        idm_raddr = IDX_W'(req.slot_id);
        if (req.valid) begin
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        // dense table holds dense_to_id[live], id table holds the entry of id_r
        unique case (op_r)
          OP_ALLOC: begin
            if (full) begin
              res_next           = base;
              res_next.status    = ST_FULL;
              res_next.result_id = '0;
              state_next         = S_RESP;
            end else begin
              rid_next   = d2i_rdata;
              idm_raddr  = d2i_rdata;
              state_next = S_FINISH;
            end
          end
          OP_FREE: begin
            if (!id_ok || not_live) begin
              res_next        = base;
              res_next.status = ST_NOT_LIVE;
              state_next      = S_RESP;
            end else begin
              pos_next     = idm_rdata.dense;
              gen_new_next = idm_rdata.gen + GEN_BITS'(1);
              d2i_raddr    = tail_pos;
              state_next   = S_FINISH;
            end
          end
          OP_LOOKUP: begin
            res_next = base;
            if (id_ok) begin
              res_next.result_generation = HGEN_W'(idm_rdata.gen);
              if (gen_match) begin
                res_next.hit         = 1'b1;
                res_next.dense_index = DENSE_W'(idm_rdata.dense);
              end
            end
            state_next = S_RESP;
          end
          OP_NOP: begin
            res_next   = base;
            state_next = S_RESP;
          end
          default: begin
            res_next   = base;
            state_next = S_RESP;
          end
        endcase
      end

      S_FINISH: begin
        unique case (op_r)
          OP_ALLOC: begin
            // id table now holds the entry of the id being handed out
            res_next                   = base;
            res_next.result_id         = ID_W'(rid);
            res_next.result_generation = HGEN_W'(idm_rdata.gen);
            res_next.dense_index       = DENSE_W'(live);
            res_next.live_count        = LIVE_W'(live_inc);
            live_next                  = live_inc;
            state_next                 = S_RESP;
          end
          OP_FREE: begin
            // dense table now holds the last live id
            last_id_next               = d2i_rdata;
            res_next                   = base;
            res_next.result_generation = HGEN_W'(gen_new);
            res_next.live_count        = LIVE_W'(live_dec);
            idm_we                     = 1'b1;
            idm_waddr                  = id_idx;
            idm_wdata.gen              = gen_new;
            if (d2i_rdata == id_idx) begin
              // freeing the last live id: bump generation only
              idm_wdata.dense = pos;
              live_next       = live_dec;
              state_next      = S_RESP;
            end else begin
              // swap: last id takes the freed position, freed id goes to the end
              idm_wdata.dense     = tail_pos;
              d2i_we              = 1'b1;
              d2i_waddr           = pos;
              d2i_wdata           = d2i_rdata;
              idm_raddr           = d2i_rdata;
              res_next.moved      = 1'b1;
              res_next.moved_from = DENSE_W'(tail_pos);
              res_next.moved_to   = DENSE_W'(pos);
              state_next          = S_MOVE;
            end
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end

      S_MOVE: begin
        // finish the swap: keep the moved id's generation, repoint its dense slot
        d2i_we          = 1'b1;
        d2i_waddr       = tail_pos;
        d2i_wdata       = id_idx;
        idm_we          = 1'b1;
        idm_waddr       = last_id;
        idm_wdata.dense = pos;
        idm_wdata.gen   = idm_rdata.gen;
        live_next       = live_dec;
        state_next      = S_RESP;
      end

      S_RESP: begin
        // hold until the output register is free
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      live      <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      live    <= live_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_r   <= op_t'(req.op);
      id_r   <= req.slot_id;
      hgen_r <= req.handle_generation;
    end
    pos     <= pos_next;
    gen_new <= gen_new_next;
    rid     <= rid_next;
    last_id <= last_id_next;
    res     <= res_next;
    if (out_load) begin
      out_word <= res;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.status            = out_word.status;
  assign rsp.result_id         = out_word.result_id;
  assign rsp.result_generation = out_word.result_generation;
  assign rsp.dense_index       = out_word.dense_index;
  assign rsp.hit               = out_word.hit;
  assign rsp.moved             = out_word.moved;
  assign rsp.moved_from        = out_word.moved_from;
  assign rsp.moved_to          = out_word.moved_to;
  assign rsp.live_count        = out_word.live_count;

endmodule

// ===== design/slm_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
module slm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/slm_checker.sv =====
// Port-level checks for the generational slot map and the bind that attaches them.
// Depends on slm_pkg and generational_slot_map_unit.
module slm_checker #(
  parameter int SLOTS = 256
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [slm_pkg::STATUS_W-1:0]  rsp_status,
  input logic [slm_pkg::HGEN_W-1:0]    rsp_result_generation,
  input logic [slm_pkg::DENSE_W-1:0]   rsp_dense_index,
  input logic                          rsp_hit,
  input logic                          rsp_moved,
  input logic [slm_pkg::DENSE_W-1:0]   rsp_moved_from,
  input logic [slm_pkg::LIVE_W-1:0]    rsp_live_count
);
  import slm_pkg::*;

  // hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_live_count) && $stable(rsp_status))
    else $error("result word dropped or changed while stalled");

  // a full report only when every slot is live
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |-> rsp_live_count == LIVE_W'(SLOTS))
    else $error("table full reported with free slots");

  // a move always comes from the position just vacated at the end of the live region
  a_move: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_moved |-> rsp_status == ST_OK && !rsp_hit &&
                               rsp_moved_from == DENSE_W'(rsp_live_count))
    else $error("move not taken from the last live position");

  // a rejected free reports no move, no hit, no generation and no dense index
  a_reject: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_NOT_LIVE |->
      !rsp_moved && !rsp_hit && rsp_result_generation == '0 && rsp_dense_index == '0)
    else $error("rejected free reported a change");

endmodule

bind generational_slot_map_unit slm_checker #(.SLOTS(SLOTS)) u_slm_checker (
  .clk                   (clk),
  .rst                   (rst),
  .rsp_valid             (rsp.valid),
  .rsp_ready             (rsp.ready),
  .rsp_status            (rsp.status),
  .rsp_result_generation (rsp.result_generation),
  .rsp_dense_index       (rsp.dense_index),
  .rsp_hit               (rsp.hit),
  .rsp_moved             (rsp.moved),
  .rsp_moved_from        (rsp.moved_from),
  .rsp_live_count        (rsp.live_count)
);

// ===== test/slot_map_monitor.sv =====
// Monitor for the generational slot map: watches the request and response channels,
// predicts every response word and compares it field by field.
// Depends on slm_pkg, slm_req_if and slm_rsp_if.
module slot_map_monitor #(
  parameter int SLOTS = 256
) (
  input  logic clk,
  input  logic rst,
  slm_req_if   req,
  slm_rsp_if   rsp,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import slm_pkg::*;

  logic [DENSE_W-1:0] slot_at_dense [SLOTS];
  logic [DENSE_W-1:0] dense_of_slot [SLOTS];
  logic [HGEN_W-1:0]  gen_of_slot   [SLOTS];
  logic [LIVE_W-1:0]  live_ids;

  rsp_word_t expected_words [$];
  int        errors;

  assign fail_count  = errors;
  assign outstanding = expected_words.size();

  // Apply one word to the shadow tables and return the response it must produce.
  function automatic rsp_word_t slot_map_predict(op_t op, logic [ID_W-1:0] id,
                                                 logic [HGEN_W-1:0] hgen);
    rsp_word_t          w;
    logic [DENSE_W-1:0] pos;
    logic [DENSE_W-1:0] last;
    logic [ID_W-1:0]    last_id;
    w = '0;
    w.status = ST_OK;
    w.result_id = id;
    case (op)
      OP_ALLOC: begin
        if (live_ids >= LIVE_W'(SLOTS)) begin
          w.status = ST_FULL;
          w.result_id = '0;
        end else begin
          w.result_id = slot_at_dense[live_ids[DENSE_W-1:0]];
          w.result_generation = gen_of_slot[w.result_id];
          w.dense_index = live_ids[DENSE_W-1:0];
          live_ids = live_ids + 1'b1;
        end
      end
      OP_FREE: begin
        if (LIVE_W'(dense_of_slot[id]) >= live_ids) begin
          w.status = ST_NOT_LIVE;
        end else begin
          pos = dense_of_slot[id];
          last = DENSE_W'(live_ids - 1'b1);
          last_id = slot_at_dense[last];
          // swap the last live id into the hole unless it is the one freed
          if (last_id != id) begin
            slot_at_dense[pos] = last_id;
            slot_at_dense[last] = id;
            dense_of_slot[last_id] = pos;
            dense_of_slot[id] = last;
            w.moved = 1'b1;
            w.moved_from = last;
            w.moved_to = pos;
          end
          gen_of_slot[id] = gen_of_slot[id] + 1'b1;
          w.result_generation = gen_of_slot[id];
          live_ids = live_ids - 1'b1;
        end
      end
      OP_LOOKUP: begin
        w.result_generation = gen_of_slot[id];
        if (gen_of_slot[id] == hgen) begin
          w.hit = 1'b1;
          w.dense_index = dense_of_slot[id];
        end
      end
      default: ;
    endcase
    w.live_count = live_ids;
    return w;
  endfunction

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", fname, want, got);
      errors++;
    end
  endfunction

  initial errors = 0;

  always @(posedge clk) begin
    rsp_word_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_at_dense[i] = DENSE_W'(i);
        dense_of_slot[i] = DENSE_W'(i);
        gen_of_slot[i] = '0;
      end
      live_ids = '0;
      expected_words.delete();
    end else begin
      // retire first: a response leaving now belongs to an older word
      if (rsp.valid && rsp.ready) begin
        if (expected_words.size() == 0) begin
          $error("response word with no request waiting");
          errors++;
        end else begin
          want = expected_words.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("result_id", want.result_id, rsp.result_id);
          check_field("result_generation", want.result_generation, rsp.result_generation);
          check_field("dense_index", want.dense_index, rsp.dense_index);
          check_field("hit", want.hit, rsp.hit);
          check_field("moved", want.moved, rsp.moved);
          check_field("moved_from", want.moved_from, rsp.moved_from);
          check_field("moved_to", want.moved_to, rsp.moved_to);
          check_field("live_count", want.live_count, rsp.live_count);
        end
      end
      if (req.valid && req.ready)
        expected_words.push_back(slot_map_predict(op_t'(req.op), req.slot_id,
                                                  req.handle_generation));
    end
  end

endmodule

// ===== test/tb_generational_slot_map_unit.sv =====
// Top of the slot map testbench: clock, reset, request stimulus, response back-pressure
// and the final verdict. Depends on slm_pkg, both channel interfaces, the
// generational_slot_map_unit RTL and slot_map_monitor.
module tb_generational_slot_map_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import slm_pkg::*;

  localparam int SLOTS       = 256;
  localparam int ITEM_TARGET = 900;
  // Worst case per word: the longest idle gap from each side plus the work of a moving
  // free, over ~900 words, plus the clearing pass and the long hold; take it several times.
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_PAD   = 10;

  logic clk;
  logic rst;

  slm_req_if req_ch();
  slm_rsp_if rsp_ch();

  int fail_count;
  int outstanding;

  // stimulus shaping state
  bit                gaps_on;
  bit                hold_rsp;
  int                sent;
  logic [LIVE_W-1:0] last_live;
  logic [LIVE_W-1:0] peak_live;

  generational_slot_map_unit #(.SLOTS(SLOTS), .GEN_BITS(16)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  slot_map_monitor #(.SLOTS(SLOTS)) u_monitor (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses a word.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_generational_slot_map_unit: done, errors");
    $finish;
  end

  // Mostly short gaps, some medium, a rare long one; none while gaps are off.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Track the live count reported by the block; ids ever handed out all lie
  // below the peak, so the peak bounds the ids worth freeing or looking up.
  always @(posedge clk) begin
    if (rst) begin
      last_live = '0;
      peak_live = '0;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      last_live = rsp_ch.live_count;
      if (rsp_ch.live_count > peak_live) peak_live = rsp_ch.live_count;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    stall = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
      end else if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        stall--;
      end else begin
        rsp_ch.ready = 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Offer one word at the falling edge and hold it until it is taken.
  task automatic send_word(op_t op, logic [ID_W-1:0] id, logic [HGEN_W-1:0] hgen);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.op = op;
    req_ch.slot_id = id;
    req_ch.handle_generation = hgen;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  // Hold the input until every outstanding response has come back.
  task automatic wait_quiet();
    req_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    if (peak_live == 0 || $urandom_range(0, 9) == 0) return ID_W'($urandom_range(0, 255));
    return ID_W'($urandom_range(0, peak_live - 1));
  endfunction

  function automatic logic [HGEN_W-1:0] pick_gen();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return HGEN_W'($urandom_range(0, 3));
    if (r < 9) return HGEN_W'($urandom_range(0, 65535));
    return (r[0]) ? 16'hFFFF : 16'h0000;
  endfunction

  // Mixed traffic: alloc_pct / free_pct set the balance, the rest is lookups
  // with a sprinkle of no-ops and frees of arbitrary ids.
  task automatic random_phase(int n, int alloc_pct, int free_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct)
        send_word(OP_ALLOC, ID_W'($urandom_range(0, 255)), HGEN_W'($urandom_range(0, 65535)));
      else if (r < alloc_pct + free_pct)
        send_word(OP_FREE, pick_id(), HGEN_W'($urandom_range(0, 65535)));
      else if (r < 95)
        send_word(OP_LOOKUP, pick_id(), pick_gen());
      else if (r < 97)
        send_word(OP_NOP, ID_W'($urandom_range(0, 255)), HGEN_W'($urandom_range(0, 65535)));
      else
        send_word(OP_FREE, ID_W'($urandom_range(0, 255)), HGEN_W'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    int fill_count;
    sent = 0;
    gaps_on = 1'b0;
    hold_rsp = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_NOP;
    req_ch.slot_id = '0;
    req_ch.handle_generation = '0;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty-table cases, a moving free, freeing the last live id,
    // lookups of dead ids that still match their generation.
    send_word(OP_LOOKUP, 8'd0, 16'h0000);    // not live, generation matches
    send_word(OP_LOOKUP, 8'd255, 16'hFFFF);  // miss
    send_word(OP_FREE, 8'd0, 16'h0000);      // not live
    send_word(OP_NOP, 8'hAA, 16'h5555);
    send_word(OP_ALLOC, 8'h00, 16'h0000);
    send_word(OP_ALLOC, 8'hFF, 16'hFFFF);
    send_word(OP_ALLOC, 8'h55, 16'hAAAA);
    send_word(OP_LOOKUP, 8'd1, 16'h0000);    // hit
    send_word(OP_FREE, 8'd0, 16'h0000);      // moves id 2 into position 0
    send_word(OP_FREE, 8'd1, 16'h0000);      // last live id, no move
    send_word(OP_LOOKUP, 8'd0, 16'h0001);    // freed id, current generation hits
    send_word(OP_LOOKUP, 8'd0, 16'h0000);    // stale handle misses
    send_word(OP_FREE, 8'd0, 16'h0000);      // double free
    send_word(OP_LOOKUP, 8'd2, 16'h0000);    // moved id now at position 0
    send_word(OP_ALLOC, 8'd0, 16'h0000);     // reuses a freed id
    send_word(OP_FREE, 8'd2, 16'h0000);
    send_word(OP_FREE, 8'd255, 16'hFFFF);    // never allocated
    send_word(OP_NOP, 8'hFF, 16'hFFFF);
    send_word(OP_NOP, 8'h00, 16'h0000);
    send_word(OP_LOOKUP, 8'd128, 16'h8000);

    // Balanced churn with idling on both sides.
    gaps_on = 1'b1;
    random_phase(150, 35, 35);

    // Drain, then fill the table to the brim and push a few allocs past full.
    wait_quiet();
    gaps_on = 1'b0;
    fill_count = SLOTS - int'(last_live) + 5;
    for (int i = 0; i < fill_count; i++)
      send_word(OP_ALLOC, ID_W'($urandom_range(0, 255)), HGEN_W'($urandom_range(0, 65535)));

    // Long receiver hold-off while the sender keeps offering words back to back.
    hold_rsp = 1'b1;
    random_phase(60, 10, 20);

    // Free-heavy drain with idling, then random mixes until the target is met.
    gaps_on = 1'b1;
    random_phase(200, 10, 60);
    while (sent < ITEM_TARGET) begin
      gaps_on = $urandom_range(0, 2) != 0;
      random_phase(60, $urandom_range(10, 60), $urandom_range(10, 50));
    end

    // Let every response come back, let the block idle, then give the verdict.
    wait_quiet();
    repeat (DRAIN_PAD) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_generational_slot_map_unit: done, clean");
    end else begin
      $display("tb_generational_slot_map_unit: done, errors");
    end
    $finish;
  end

endmodule

// ===== generational_slot_map_unit.f =====
design/slm_pkg.sv
design/slm_req_if.sv
design/slm_rsp_if.sv
design/slm_ram.sv
design/generational_slot_map_unit.sv
design/slm_checker.sv
test/slot_map_monitor.sv
test/tb_generational_slot_map_unit.sv
